// File: sv/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ecm_pkg.sv
package ecm_pkg;

    localparam logic [7:0] FLAG_OBF = 8'h01;
    localparam logic [7:0] FLAG_IBF = 8'h02;

    localparam int RES_DEPTH = 8;

    localparam logic [2:0] CFG_DATA_PORT     = 3'd0;
    localparam logic [2:0] CFG_COMMAND_PORT  = 3'd1;
    localparam logic [2:0] CFG_READ_COMMAND  = 3'd2;
    localparam logic [2:0] CFG_WRITE_COMMAND = 3'd3;
    localparam logic [2:0] CFG_POLL_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_RETRY_LIMIT   = 3'd5;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_STATUS  = 2'd1,
        ACT_DATA    = 2'd2,
        ACT_TICK    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_WAIT_CMD   = 3'd1,
        PH_WAIT_REG   = 3'd2,
        PH_WAIT_FINAL = 3'd3,
        PH_WAIT_OBF   = 3'd4,
        PH_READ_DATA  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_port;
        logic [7:0] command_port;
        logic [7:0] read_command;
        logic [7:0] write_command;
        logic [7:0] poll_limit;
        logic [3:0] retry_limit;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic       is_read;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic [7:0] bus_reply;
    } t_req;

    // Declared high to low so that bus_valid sits in bit 0.
    typedef struct packed {
        logic [7:0] read_value;
        logic       success;
        logic       done_res;
        logic [7:0] bus_wdata;
        logic       bus_is_write;
        logic [7:0] bus_port;
        logic       bus_valid;
    } t_res;

    typedef struct packed {
        logic last;
        t_res res;
    } t_res_item;

    typedef struct packed {
        logic      push0;
        logic      push1;
        t_res_item item0;
        t_res_item item1;
    } t_push;

    function automatic t_res f_access(input logic [7:0] port, input logic wr,
                                      input logic [7:0] wdata);
        t_res r;
        r              = '0;
        r.bus_valid    = 1'b1;
        r.bus_port     = port;
        r.bus_is_write = wr;
        r.bus_wdata    = wdata;
        return r;
    endfunction

    function automatic t_res f_done(input logic ok, input logic [7:0] rval);
        t_res r;
        r            = '0;
        r.done_res   = 1'b1;
        r.success    = ok;
        r.read_value = rval;
        return r;
    endfunction

endpackage

// File: sv/ecm_fsm.sv
`include "assert_macros.svh"

module ecm_fsm
    import ecm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_req  i_req,
    input  t_cfg  i_cfg,
    output t_push o_push
);

    t_phase     r_phase,  n_phase;
    logic       r_op_read, n_op_read;
    logic [7:0] r_saved_register, n_saved_register;
    logic [7:0] r_saved_data, n_saved_data;
    logic [7:0] r_poll_count, n_poll_count;
    logic [3:0] r_attempt_count, n_attempt_count;
    logic       r_tick_wait, n_tick_wait;

    logic       w_in_wait;
    logic       w_status_ok;
    logic       w_no_polls;
    logic [3:0] w_attempt_inc;
    logic       w_retry_out;
    logic       w_poll_out;
    t_res       w_wait_res;

    assign w_in_wait = r_phase inside {PH_WAIT_CMD, PH_WAIT_REG, PH_WAIT_FINAL, PH_WAIT_OBF};
    assign w_status_ok = (r_phase == PH_WAIT_OBF) ? ((i_req.bus_reply & FLAG_OBF) != 8'h00)
                                                  : ((i_req.bus_reply & FLAG_IBF) == 8'h00);
    assign w_no_polls    = (i_cfg.poll_limit == 8'h00);
    assign w_attempt_inc = (r_attempt_count != 4'hF) ? r_attempt_count + 4'd1 : r_attempt_count;
    assign w_retry_out   = (w_attempt_inc >= i_cfg.retry_limit);
    assign w_poll_out    = (r_poll_count >= i_cfg.poll_limit);
    assign w_wait_res    = w_no_polls ? f_done(1'b0, 8'h00)
                                      : f_access(i_cfg.command_port, 1'b0, 8'h00);

    always_comb begin
        n_phase          = r_phase;
        n_op_read        = r_op_read;
        n_saved_register = r_saved_register;
        n_saved_data     = r_saved_data;
        n_poll_count     = r_poll_count;
        n_attempt_count  = r_attempt_count;
        n_tick_wait      = r_tick_wait;
        if (i_valid) begin
            case (i_req.action)
                ACT_REQUEST: begin
                    if (r_phase == PH_IDLE) begin
                        n_op_read        = i_req.is_read;
                        n_saved_register = i_req.register_address;
                        n_saved_data     = i_req.write_data;
                        n_attempt_count  = 4'd0;
                        n_poll_count     = 8'h00;
                        n_tick_wait      = 1'b0;
                        if (i_cfg.retry_limit != 4'd0 && !w_no_polls) begin
                            n_phase = PH_WAIT_CMD;
                        end
                    end
                end
                ACT_STATUS: begin
                    if (w_in_wait && !r_tick_wait) begin
                        if (!w_status_ok) begin
                            if (r_poll_count != 8'hFF) begin
                                n_poll_count = r_poll_count + 8'd1;
                            end
                            n_tick_wait = 1'b1;
                        end else begin
                            n_poll_count = 8'h00;
                            case (r_phase)
                                PH_WAIT_CMD:   n_phase = w_no_polls ? PH_IDLE : PH_WAIT_REG;
                                PH_WAIT_REG:   n_phase = w_no_polls ? PH_IDLE : PH_WAIT_FINAL;
                                PH_WAIT_FINAL: begin
                                    n_phase = (r_op_read && !w_no_polls) ? PH_WAIT_OBF : PH_IDLE;
                                end
                                default:       n_phase = PH_READ_DATA;
                            endcase
                        end
                    end
                end
                ACT_DATA: begin
                    if (r_phase == PH_READ_DATA) begin
                        n_phase      = PH_IDLE;
                        n_poll_count = 8'h00;
                        n_tick_wait  = 1'b0;
                    end
                end
                default: begin
                    if (r_tick_wait && w_in_wait) begin
                        n_tick_wait = 1'b0;
                        if (w_poll_out) begin
                            n_attempt_count = w_attempt_inc;
                            n_poll_count    = 8'h00;
                            n_phase         = (w_retry_out || w_no_polls) ? PH_IDLE : PH_WAIT_CMD;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_push = '0;
        if (i_valid) begin
            case (i_req.action)
                ACT_REQUEST: begin
                    if (r_phase == PH_IDLE) begin
                        o_push.push0     = 1'b1;
                        o_push.item0.res = (i_cfg.retry_limit == 4'd0) ? f_done(1'b0, 8'h00)
                                                                       : w_wait_res;
                    end
                end
                ACT_STATUS: begin
                    if (w_in_wait && !r_tick_wait && w_status_ok) begin
                        o_push.push0 = 1'b1;
                        case (r_phase)
                            PH_WAIT_CMD: begin
                                o_push.item0.res = f_access(i_cfg.command_port, 1'b1,
                                    r_op_read ? i_cfg.read_command : i_cfg.write_command);
                                o_push.push1     = 1'b1;
                                o_push.item1.res = w_wait_res;
                            end
                            PH_WAIT_REG: begin
                                o_push.item0.res = f_access(i_cfg.data_port, 1'b1,
                                                            r_saved_register);
                                o_push.push1     = 1'b1;
                                o_push.item1.res = w_wait_res;
                            end
                            PH_WAIT_FINAL: begin
                                if (r_op_read) begin
                                    o_push.item0.res = w_wait_res;
                                end else begin
                                    o_push.item0.res = f_access(i_cfg.data_port, 1'b1,
                                                                r_saved_data);
                                    o_push.push1     = 1'b1;
                                    o_push.item1.res = f_done(1'b1, 8'h00);
                                end
                            end
                            default: begin
                                o_push.item0.res = f_access(i_cfg.data_port, 1'b0, 8'h00);
                            end
                        endcase
                    end
                end
                ACT_DATA: begin
                    if (r_phase == PH_READ_DATA) begin
                        o_push.push0     = 1'b1;
                        o_push.item0.res = f_done(1'b1, i_req.bus_reply);
                    end
                end
                default: begin
                    if (r_tick_wait && w_in_wait) begin
                        o_push.push0 = 1'b1;
                        if (!w_poll_out) begin
                            o_push.item0.res = f_access(i_cfg.command_port, 1'b0, 8'h00);
                        end else if (w_retry_out) begin
                            o_push.item0.res = f_done(1'b0, 8'h00);
                        end else begin
                            o_push.item0.res = w_wait_res;
                        end
                    end
                end
            endcase
        end
        o_push.item0.last = o_push.push0 && !o_push.push1;
        o_push.item1.last = o_push.push1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_op_read        <= 1'b0;
            r_saved_register <= 8'h00;
            r_saved_data     <= 8'h00;
            r_poll_count     <= 8'h00;
            r_attempt_count  <= 4'd0;
            r_tick_wait      <= 1'b0;
        end else begin
            r_phase          <= n_phase;
            r_op_read        <= n_op_read;
            r_saved_register <= n_saved_register;
            r_saved_data     <= n_saved_data;
            r_poll_count     <= n_poll_count;
            r_attempt_count  <= n_attempt_count;
            r_tick_wait      <= n_tick_wait;
        end
    end

    `ASSERT_IMPLIES(a_idle_no_tick, i_clk, i_rst_n, r_phase == PH_IDLE, !r_tick_wait, "tick pending while idle")
    `ASSERT_IMPLIES(a_read_data_is_read, i_clk, i_rst_n, r_phase == PH_READ_DATA, r_op_read, "data phase on a write")
    `ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n, (o_push.push0 && o_push.item0.res.done_res) || (o_push.push1 && o_push.item1.res.done_res), r_phase == PH_IDLE, "done without return to idle")

endmodule

// File: sv/ecm_res_fifo.sv
`include "assert_macros.svh"

module ecm_res_fifo
    import ecm_pkg::*;
#(
    parameter int Depth = RES_DEPTH
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_push                      i_push,
    input  logic                       i_pop,
    output t_res_item                  o_head,
    output logic [$clog2(Depth+1)-1:0] o_count
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth+1);

    t_res_item       r_mem [Depth];
    t_res_item       r_head;
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   w_wr_next;
    logic            w_pop;
    logic [CW-1:0]   w_fill;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_wr_next = f_inc(r_wr_ptr);
    assign w_pop     = i_pop && (r_count != '0);
    assign w_fill    = r_count + CW'(i_push.push1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.push0 && i_push.push1) begin
            n_wr_ptr = f_inc(w_wr_next);
        end else if (i_push.push0) begin
            n_wr_ptr = w_wr_next;
        end
        n_rd_ptr = w_pop ? f_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.push1) begin
            r_mem[w_wr_next] <= i_push.item1;
        end
        // Load the next head, taking a result written in this same cycle
        if (i_push.push0 && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_push.item0;
        end else if (i_push.push1 && (w_wr_next == n_rd_ptr)) begin
            r_head <= i_push.item1;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_head  = r_head;
    assign o_count = r_count;

    `ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push.push0, w_fill < CW'(Depth), "queue overflow")
    `ASSERT_IMPLIES(a_push_order, i_clk, i_rst_n, i_push.push1, i_push.push0, "second push alone")
    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(Depth), "count out of range")

endmodule

// File: sv/ec_host_transaction_master_unit.sv
// Host-side master for one embedded controller register read or write. A request on the slave
// stream (tuser 0) starts a transaction; status replies (1), data replies (2) and poll ticks (3)
// drive it forward, and each port access to issue and the final done/success report leave on the
// master stream, tlast marking the final result of each input. The slave side takes one item per
// cycle as long as the result queue has room: an input is registered, handled in the next cycle by
// the transaction state machine and leaves one or two results in a queue of Depth entries, which
// the master side drains at one result per cycle while m_axis_tready is high. An input that makes
// two results (command or register write followed by a status read, data write followed by done)
// queues both; the queue depth sets how long such bursts can be absorbed before tready drops.
`include "assert_macros.svh"

module ec_host_transaction_master_unit
    import ecm_pkg::*;
#(
    parameter int Depth = RES_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] is_read, [8:1] register_address, [16:9] write_data, [24:17] bus_reply
    input  logic [31:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] bus_valid, [8:1] bus_port, [9] bus_is_write, [17:10] bus_wdata, [18] done_res,
    // [19] success, [27:20] read_value
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    localparam int CW = $clog2(Depth+1);

    t_cfg          r_cfg;
    logic          r_in_valid;
    t_req          r_in;
    t_push         w_push;
    t_res_item     w_head;
    logic [CW-1:0] w_count;
    logic [CW:0]   w_need;
    logic          w_accept;

    assign w_need        = {1'b0, w_count} + (r_in_valid ? (CW+1)'(4) : (CW+1)'(2));
    assign s_axis_tready = (w_need <= (CW+1)'(Depth));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_port     <= 8'h62;
            r_cfg.command_port  <= 8'h66;
            r_cfg.read_command  <= 8'h80;
            r_cfg.write_command <= 8'h81;
            r_cfg.poll_limit    <= 8'd100;
            r_cfg.retry_limit   <= 4'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DATA_PORT:     r_cfg.data_port     <= i_cfg_wdata;
                CFG_COMMAND_PORT:  r_cfg.command_port  <= i_cfg_wdata;
                CFG_READ_COMMAND:  r_cfg.read_command  <= i_cfg_wdata;
                CFG_WRITE_COMMAND: r_cfg.write_command <= i_cfg_wdata;
                CFG_POLL_LIMIT:    r_cfg.poll_limit    <= i_cfg_wdata;
                CFG_RETRY_LIMIT:   r_cfg.retry_limit   <= i_cfg_wdata[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.action           <= t_action'(s_axis_tuser);
            r_in.is_read          <= s_axis_tdata[0];
            r_in.register_address <= s_axis_tdata[8:1];
            r_in.write_data       <= s_axis_tdata[16:9];
            r_in.bus_reply        <= s_axis_tdata[24:17];
        end
    end

    ecm_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_push  (w_push)
    );

    ecm_res_fifo #(
        .Depth (Depth)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (m_axis_tready),
        .o_head  (w_head),
        .o_count (w_count)
    );

    assign m_axis_tvalid = (w_count != '0);
    assign m_axis_tdata  = {4'b0000, w_head.res};
    assign m_axis_tlast  = w_head.last;

    `ASSERT_NEXT(a_accept_registers, i_clk, i_rst_n, w_accept, r_in_valid, "accepted request not registered")
    `ASSERT_IMPLIES(a_room_for_pending, i_clk, i_rst_n, r_in_valid && s_axis_tready, ({1'b0, w_count} + (CW+1)'(4)) <= (CW+1)'(Depth), "no room for pending results")
    `ASSERT_IMPLIES(a_valid_has_data, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, w_count != '0, "last flag with empty queue")

endmodule

// File: bench/tb_ec_host_transaction_master_unit.sv
`timescale 1ns / 1ps

module tb_ec_host_transaction_master_unit
    import ecm_pkg::*;
();

class ec_txn_tracker;
    t_cfg       cfg;
    t_phase     phase;
    bit         op_read;
    logic [7:0] reg_num;
    logic [7:0] wr_byte;
    logic [7:0] polls;
    logic [3:0] attempts;
    bit         tick_pending;
    t_res_item  due_results[$];
    int         errors;

    function new();
        cfg.data_port     = 8'h62;
        cfg.command_port  = 8'h66;
        cfg.read_command  = 8'h80;
        cfg.write_command = 8'h81;
        cfg.poll_limit    = 8'd100;
        cfg.retry_limit   = 4'd5;
        phase        = PH_IDLE;
        op_read      = 1'b0;
        reg_num      = 8'd0;
        wr_byte      = 8'd0;
        polls        = 8'd0;
        attempts     = 4'd0;
        tick_pending = 1'b0;
        errors       = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
        case (idx)
            CFG_DATA_PORT:     cfg.data_port = v;
            CFG_COMMAND_PORT:  cfg.command_port = v;
            CFG_READ_COMMAND:  cfg.read_command = v;
            CFG_WRITE_COMMAND: cfg.write_command = v;
            CFG_POLL_LIMIT:    cfg.poll_limit = v;
            CFG_RETRY_LIMIT:   cfg.retry_limit = v[3:0];
            default: ;
        endcase
    endfunction

    function void push(t_res r);
        t_res_item it;
        it.last = 1'b0;
        it.res  = r;
        due_results.push_back(it);
    endfunction

    function void port_access(logic [7:0] port, logic wr, logic [7:0] wdata);
        t_res r;
        r              = '0;
        r.bus_valid    = 1'b1;
        r.bus_port     = port;
        r.bus_is_write = wr;
        r.bus_wdata    = wdata;
        push(r);
    endfunction

    function void end_txn(logic ok, logic [7:0] rval);
        t_res r;
        r            = '0;
        r.done_res   = 1'b1;
        r.success    = ok;
        r.read_value = rval;
        push(r);
        phase        = PH_IDLE;
        tick_pending = 1'b0;
        polls        = 8'd0;
    endfunction

    // Enter a wait: poll status, or give up at once when no polls are allowed.
    function void open_wait(t_phase ph);
        phase        = ph;
        polls        = 8'd0;
        tick_pending = 1'b0;
        if (cfg.poll_limit == 8'd0)
            end_txn(1'b0, 8'd0);
        else
            port_access(cfg.command_port, 1'b0, 8'd0);
    endfunction

    function void retry_or_give_up();
        if (attempts < 4'd15)
            attempts++;
        if (attempts >= cfg.retry_limit)
            end_txn(1'b0, 8'd0);
        else
            open_wait(PH_WAIT_CMD);
    endfunction

    function bit in_wait();
        return phase >= PH_WAIT_CMD && phase <= PH_WAIT_OBF;
    endfunction

    function void note_item(t_req r);
        int before_n;
        bit ok;
        before_n = due_results.size();
        case (r.action)
            ACT_REQUEST: if (phase == PH_IDLE) begin
                op_read  = r.is_read;
                reg_num  = r.register_address;
                wr_byte  = r.write_data;
                attempts = 4'd0;
                if (cfg.retry_limit == 4'd0)
                    end_txn(1'b0, 8'd0);
                else
                    open_wait(PH_WAIT_CMD);
            end
            ACT_STATUS: if (in_wait() && !tick_pending) begin
                ok = (phase == PH_WAIT_OBF) ? ((r.bus_reply & FLAG_OBF) != 8'd0)
                                            : ((r.bus_reply & FLAG_IBF) == 8'd0);
                if (!ok) begin
                    if (polls < 8'd255)
                        polls++;
                    tick_pending = 1'b1;
                end else begin
                    case (phase)
                        PH_WAIT_CMD: begin
                            port_access(cfg.command_port, 1'b1,
                                        op_read ? cfg.read_command : cfg.write_command);
                            open_wait(PH_WAIT_REG);
                        end
                        PH_WAIT_REG: begin
                            port_access(cfg.data_port, 1'b1, reg_num);
                            open_wait(PH_WAIT_FINAL);
                        end
                        PH_WAIT_FINAL: begin
                            if (op_read) begin
                                open_wait(PH_WAIT_OBF);
                            end else begin
                                port_access(cfg.data_port, 1'b1, wr_byte);
                                end_txn(1'b1, 8'd0);
                            end
                        end
                        default: begin
                            port_access(cfg.data_port, 1'b0, 8'd0);
                            phase = PH_READ_DATA;
                            polls = 8'd0;
                        end
                    endcase
                end
            end
            ACT_DATA: if (phase == PH_READ_DATA) begin
                end_txn(1'b1, r.bus_reply);
            end
            default: if (tick_pending && in_wait()) begin
                tick_pending = 1'b0;
                if (polls >= cfg.poll_limit)
                    retry_or_give_up();
                else
                    port_access(cfg.command_port, 1'b0, 8'd0);
            end
        endcase
        if (due_results.size() > before_n)
            due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(logic [31:0] data, logic last);
        t_res_item want;
        t_res      got;
        if (due_results.size() == 0) begin
            report($sformatf("result %h with none pending", data));
            return;
        end
        want = due_results.pop_front();
        got  = t_res'(data[27:0]);
        check_field("bus_valid", 8'(got.bus_valid), 8'(want.res.bus_valid));
        check_field("bus_port", got.bus_port, want.res.bus_port);
        check_field("bus_is_write", 8'(got.bus_is_write), 8'(want.res.bus_is_write));
        check_field("bus_wdata", got.bus_wdata, want.res.bus_wdata);
        check_field("done_res", 8'(got.done_res), 8'(want.res.done_res));
        check_field("success", 8'(got.success), 8'(want.res.success));
        check_field("read_value", got.read_value, want.res.read_value);
        check_field("pad", 8'(data[31:28]), 8'd0);
        check_field("tlast", 8'(last), 8'(want.last));
    endtask
endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_wdata;

    ec_txn_tracker tracker;
    int            bad_pct;
    bit            gaps_on;
    bit            hold_req;
    int            idle_cycles = 0;

    ec_host_transaction_master_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        int hold_left;
        bit hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 200;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = !(gaps_on && $urandom_range(0, 99) < 29);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata, m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_req make_item(t_action a, logic rd, logic [7:0] ra, logic [7:0] wd,
                                       logic [7:0] rep);
        t_req r;
        r.action           = a;
        r.is_read          = rd;
        r.register_address = ra;
        r.write_data       = wd;
        r.bus_reply        = rep;
        return r;
    endfunction

    // Pick the request that moves the transaction on, with some noise mixed in.
    function automatic t_req next_item(bit clean);
        t_req r;
        bit   bad;
        r.action           = t_action'(2'($urandom_range(0, 3)));
        r.is_read          = 1'($urandom_range(0, 1));
        r.register_address = 8'($urandom_range(0, 255));
        r.write_data       = 8'($urandom_range(0, 255));
        r.bus_reply        = 8'($urandom_range(0, 255));
        bad = $urandom_range(0, 99) < bad_pct;
        if (!clean && $urandom_range(0, 99) < 12)
            return r;
        if (tracker.phase == PH_IDLE) begin
            r.action = ACT_REQUEST;
        end else if (tracker.phase == PH_READ_DATA) begin
            r.action = ACT_DATA;
        end else if (tracker.tick_pending) begin
            r.action = ACT_TICK;
        end else begin
            r.action = ACT_STATUS;
            if (tracker.phase == PH_WAIT_OBF)
                r.bus_reply = bad ? (r.bus_reply & ~FLAG_OBF) : (r.bus_reply | FLAG_OBF);
            else
                r.bus_reply = bad ? (r.bus_reply | FLAG_IBF) : (r.bus_reply & ~FLAG_IBF);
        end
        return r;
    endfunction

    task automatic send(input t_req r);
        while (gaps_on && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, r.bus_reply, r.write_data, r.register_address, r.is_read};
        s_axis_tuser  = r.action;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tracker.note_item(r);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (tracker.due_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = v;
        tracker.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] dp, input logic [7:0] cp,
                                input logic [7:0] rc, input logic [7:0] wc,
                                input logic [7:0] pl, input logic [7:0] rl);
        write_reg(CFG_DATA_PORT, dp);
        write_reg(CFG_COMMAND_PORT, cp);
        write_reg(CFG_READ_COMMAND, rc);
        write_reg(CFG_WRITE_COMMAND, wc);
        write_reg(CFG_POLL_LIMIT, pl);
        write_reg(CFG_RETRY_LIMIT, rl);
    endtask

    task automatic run_phase(input int count, input bit with_pressure);
        for (int i = 0; i < count; i++) begin
            if (with_pressure) begin
                gaps_on = (i >= 100);
                if (i == 130)
                    hold_req = 1'b1;
            end
            send(next_item(1'b0));
        end
        gaps_on = 1'b1;
        // finish the open transaction so the block is idle before reprogramming
        while (tracker.phase != PH_IDLE)
            send(next_item(1'b1));
        settle();
    endtask

    initial begin
        tracker       = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        bad_pct       = 30;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // write with a busy poll, then unexpected replies while idle
        send(make_item(ACT_REQUEST, 1'b0, 8'hFF, 8'hFF, 8'h00));
        send(make_item(ACT_STATUS,  1'b1, 8'h00, 8'h00, 8'hFF));
        send(make_item(ACT_TICK,    1'b0, 8'hFF, 8'hFF, 8'h00));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_STATUS,  1'b1, 8'hFF, 8'hFF, 8'hFD));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h01));
        send(make_item(ACT_DATA,    1'b1, 8'hFF, 8'hFF, 8'hFF));
        send(make_item(ACT_TICK,    1'b1, 8'hFF, 8'hFF, 8'hFF));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h00));
        // read with a request while busy, stray tick and data, OBF poll
        send(make_item(ACT_REQUEST, 1'b1, 8'h00, 8'h00, 8'hFF));
        send(make_item(ACT_REQUEST, 1'b0, 8'h55, 8'hAA, 8'h00));
        send(make_item(ACT_TICK,    1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_DATA,    1'b0, 8'h00, 8'h00, 8'h33));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'hFE));
        send(make_item(ACT_TICK,    1'b0, 8'h00, 8'h00, 8'h00));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h01));
        send(make_item(ACT_STATUS,  1'b0, 8'h00, 8'h00, 8'h01));
        send(make_item(ACT_DATA,    1'b0, 8'h00, 8'h00, 8'hA5));
        settle();

        bad_pct = 35;
        program_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 8'd1, 8'd1);
        run_phase(220, 1'b0);

        bad_pct = 30;
        program_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 8'd255, 8'd15);
        run_phase(220, 1'b0);

        bad_pct = 40;
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd2, 8'd3);
        run_phase(260, 1'b1);

        write_reg(CFG_RETRY_LIMIT, 8'd0);
        run_phase(20, 1'b0);

        write_reg(CFG_RETRY_LIMIT, 8'd4);
        write_reg(CFG_POLL_LIMIT, 8'd0);
        run_phase(20, 1'b0);

        bad_pct = 30;
        program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(1, 6)), 8'($urandom_range(1, 15)));
        run_phase(300, 1'b0);

        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
